@@ src/usb_packet_deframe_filter_top_macros.svh @@
// Assertion macros used by the checker of the deframer.
`ifndef USB_PACKET_DEFRAME_FILTER_TOP_MACROS_SVH
`define USB_PACKET_DEFRAME_FILTER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define UPDF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define UPDF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/updf_pkg.sv @@
`default_nettype none

package updf_pkg;

    localparam logic [31:0] EOP_WORD        = 32'hFFFF_FFFF;
    localparam logic [7:0]  SYNC_BYTE       = 8'h80;
    localparam int          BYTE_SHIFT      = 24;
    localparam logic [15:0] DROP_MASK_RESET = 16'h0024;

    // Number of bytes seen in the current packet, saturating at three.
    typedef enum logic [1:0] {
        POS_NONE = 2'd0,
        POS_ONE  = 2'd1,
        POS_TWO  = 2'd2,
        POS_MANY = 2'd3
    } pos_t;

    // Content of the input register as seen by the deframing logic.
    typedef struct packed {
        logic        valid;
        logic [31:0] word;
    } updf_item_t;

endpackage

`default_nettype wire

@@ src/updf_in_stage.sv @@
`default_nettype none

module updf_in_stage
    import updf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] capture_word,
    input  wire logic        advance,
    output updf_item_t       item
);

    logic        valid_reg;
    logic        valid_next;
    logic [31:0] word_reg;
    logic        accept;

    // The register may be refilled in the same cycle its item moves on.
    assign in_stall = valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg <= capture_word;
        end
    end

    assign item.valid = valid_reg;
    assign item.word  = word_reg;

endmodule

`default_nettype wire

@@ src/updf_core.sv @@
`default_nettype none

module updf_core
    import updf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire updf_item_t  item,
    output logic             advance,
    input  wire logic        cfg_write,
    input  wire logic [15:0] cfg_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       packet_byte,
    output logic             last_byte
);

    logic [15:0] mask_reg;
    pos_t        pos_reg;
    pos_t        pos_next;
    logic        reject_reg;
    logic        reject_next;
    logic [7:0]  held_reg;
    logic [7:0]  held_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  out_byte_reg;
    logic        out_last_reg;

    logic        is_eop;
    logic [7:0]  line_byte;
    logic        emit;
    logic        emit_last;

    // An item moves on only when the result register is free or being emptied.
    assign advance   = item.valid && (!out_valid_reg || !out_stall);
    assign is_eop    = (item.word == EOP_WORD);
    assign line_byte = item.word[BYTE_SHIFT +: 8];

    always_comb
    begin
        pos_next    = pos_reg;
        reject_next = reject_reg;
        held_next   = held_reg;
        emit        = 1'b0;
        emit_last   = 1'b0;
        if (is_eop)
        begin
            emit        = (pos_reg == POS_MANY) && !reject_reg;
            emit_last   = 1'b1;
            pos_next    = POS_NONE;
            reject_next = 1'b0;
        end
        else
        begin
            unique case (pos_reg)
                POS_NONE:
                begin
                    if (line_byte != SYNC_BYTE)
                    begin
                        reject_next = 1'b1;
                    end
                    pos_next = POS_ONE;
                end
                POS_ONE:
                begin
                    // The PID is valid when its upper nibble complements the lower.
                    if ((~line_byte[7:4]) != line_byte[3:0] || mask_reg[line_byte[3:0]])
                    begin
                        reject_next = 1'b1;
                    end
                    held_next = line_byte;
                    pos_next  = POS_TWO;
                end
                POS_TWO, POS_MANY:
                begin
                    emit      = !reject_reg;
                    held_next = line_byte;
                    pos_next  = POS_MANY;
                end
            endcase
        end
    end

    always_comb
    begin
        if (advance && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= DROP_MASK_RESET;
            pos_reg       <= POS_NONE;
            reject_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                mask_reg <= cfg_data;
            end
            if (advance)
            begin
                pos_reg    <= pos_next;
                reject_reg <= reject_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            held_reg <= held_next;
        end
        if (advance && emit)
        begin
            out_byte_reg <= held_reg;
            out_last_reg <= emit_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign packet_byte = out_byte_reg;
    assign last_byte   = out_last_reg;

endmodule

`default_nettype wire

@@ src/usb_packet_deframe_filter_top.sv @@
// USB packet deframer with PID filter. One capture word is taken per cycle
// while in_stall is low; each sent byte passes from the input register through
// the held register into the result register. in_stall rises only while
// the result register holds a byte that the sink is stalling. A packet
// must open with sync 0x80, have at least three bytes and carry a valid
// PID whose type bit in the drop mask is clear (reset value drops ACK
// and SOF); its bytes are sent from the PID onward, one item each, with the
// final byte marked by last_byte. The mask may be written at any time
// (cfg_ready is always high); it is sampled when a packet's PID byte leaves
// the input register, so it should only be written while no item is in flight.
`default_nettype none

module usb_packet_deframe_filter_top
    import updf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] capture_word,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       packet_byte,
    output logic             last_byte,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);

    updf_item_t item;
    logic       advance;

    assign cfg_ready = 1'b1;

    updf_in_stage u_in_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .capture_word (capture_word),
        .advance      (advance),
        .item         (item)
    );

    updf_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .advance     (advance),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .packet_byte (packet_byte),
        .last_byte   (last_byte)
    );

endmodule

`default_nettype wire

@@ src/updf_checker.sv @@
`default_nettype none
`include "usb_packet_deframe_filter_top_macros.svh"

module updf_checker
    import updf_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic [31:0] capture_word,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [7:0]  packet_byte,
    input wire logic        last_byte
);

    // A held result must not change while the sink stalls it.
    `UPDF_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(packet_byte) && $stable(last_byte), "stalled result changed")

    // The input side only backs up behind a stalled result.
    `UPDF_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without a stalled result")

    // A fresh result always comes from an item accepted into the input register.
    `UPDF_ASSERT_IMP(a_result_source, $rose(out_valid), $past(in_valid && !in_stall, 2), "result without an accepted item")

    // A final byte is released only by an end of packet marker.
    `UPDF_ASSERT_IMP(a_last_from_eop, $rose(out_valid) && last_byte, $past(capture_word == EOP_WORD, 2), "last byte without end marker")

endmodule

bind usb_packet_deframe_filter_top updf_checker u_updf_checker (.*);

`default_nettype wire
